FILE: hdl/smpt_pkg.sv
`default_nettype none

package smpt_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int CFG_IDX_BITS   = 3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_MASK_ENABLE   = 3'd0,
        REG_SHAPE_KIND    = 3'd1,
        REG_OFFSET_X      = 3'd2,
        REG_OFFSET_Y      = 3'd3,
        REG_SIZE_W        = 3'd4,
        REG_SIZE_H        = 3'd5,
        REG_CORNER_RADIUS = 3'd6,
        REG_INVERT_MASK   = 3'd7
    } cfg_reg_t;

    typedef enum logic [1:0] {
        SHAPE_RECT    = 2'd0,
        SHAPE_RRECT   = 2'd1,
        SHAPE_CIRCLE  = 2'd2,
        SHAPE_UNKNOWN = 2'd3
    } shape_t;

    // per-item control carried from the geometry stage to the distance stage
    typedef struct packed {
        logic valid;
        logic en;
        logic need_sq;
        logic pre;
        logic inv;
    } geom_flags_t;

endpackage

`default_nettype wire

FILE: hdl/smpt_cfg.sv
`default_nettype none

module smpt_cfg
    import smpt_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         wr_en,
    input  wire logic [CFG_IDX_BITS-1:0]      wr_index,
    input  wire logic [COORD_BITS-1:0]        wr_data,
    output logic                              mask_enable,
    output shape_t                            shape_kind,
    output logic signed [COORD_BITS-1:0]      offset_x,
    output logic signed [COORD_BITS-1:0]      offset_y,
    output logic [COORD_BITS-1:0]             size_w,
    output logic [COORD_BITS-1:0]             size_h,
    output logic [COORD_BITS-2:0]             corner_radius,
    output logic                              invert_mask
);

    logic                  mask_enable_reg;
    logic [1:0]            shape_kind_reg;
    logic [COORD_BITS-1:0] offset_x_reg;
    logic [COORD_BITS-1:0] offset_y_reg;
    logic [COORD_BITS-1:0] size_w_reg;
    logic [COORD_BITS-1:0] size_h_reg;
    logic [COORD_BITS-2:0] corner_radius_reg;
    logic                  invert_mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_enable_reg   <= 1'b0;
            shape_kind_reg    <= 2'd0;
            offset_x_reg      <= '0;
            offset_y_reg      <= '0;
            size_w_reg        <= '0;
            size_h_reg        <= '0;
            corner_radius_reg <= '0;
            invert_mask_reg   <= 1'b0;
        end
        else if (wr_en)
        begin
            case (cfg_reg_t'(wr_index))
                REG_MASK_ENABLE:   mask_enable_reg   <= wr_data[0];
                REG_SHAPE_KIND:    shape_kind_reg    <= wr_data[1:0];
                REG_OFFSET_X:      offset_x_reg      <= wr_data;
                REG_OFFSET_Y:      offset_y_reg      <= wr_data;
                REG_SIZE_W:        size_w_reg        <= wr_data;
                REG_SIZE_H:        size_h_reg        <= wr_data;
                REG_CORNER_RADIUS: corner_radius_reg <= wr_data[COORD_BITS-2:0];
                REG_INVERT_MASK:   invert_mask_reg   <= wr_data[0];
                default:           mask_enable_reg   <= mask_enable_reg;
            endcase
        end
    end

    assign mask_enable   = mask_enable_reg;
    assign shape_kind    = shape_t'(shape_kind_reg);
    assign offset_x      = offset_x_reg;
    assign offset_y      = offset_y_reg;
    assign size_w        = size_w_reg;
    assign size_h        = size_h_reg;
    assign corner_radius = corner_radius_reg;
    assign invert_mask   = invert_mask_reg;

endmodule

`default_nettype wire

FILE: hdl/smpt_geom.sv
`default_nettype none

module smpt_geom
    import smpt_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_vld,
    input  wire logic signed [COORD_BITS-1:0] point_x,
    input  wire logic signed [COORD_BITS-1:0] point_y,
    input  wire logic                         mask_enable,
    input  wire shape_t                       shape_kind,
    input  wire logic signed [COORD_BITS-1:0] offset_x,
    input  wire logic signed [COORD_BITS-1:0] offset_y,
    input  wire logic [COORD_BITS-1:0]        size_w,
    input  wire logic [COORD_BITS-1:0]        size_h,
    input  wire logic [COORD_BITS-2:0]        corner_radius,
    input  wire logic                         invert_mask,
    output logic [COORD_BITS:0]               a_out,
    output logic [COORD_BITS:0]               b_out,
    output logic [COORD_BITS-1:0]             r_out,
    output geom_flags_t                       flags
);

    localparam int C = COORD_BITS;

    logic          in_vld_reg;
    logic [C-1:0]  px_reg;
    logic [C-1:0]  py_reg;

    logic [C:0]    dx;
    logic [C:0]    dy;
    logic [C:0]    dx_neg;
    logic [C:0]    dy_neg;
    logic [C-1:0]  mag_x;
    logic [C-1:0]  mag_y;
    logic [C:0]    ax;
    logic [C:0]    ay;
    logic [C:0]    hw;
    logic [C:0]    hh;
    logic [C-1:0]  r2;
    logic [C-1:0]  rc_w;
    logic [C-1:0]  rc;
    logic [C-1:0]  iw;
    logic [C-1:0]  ih;
    logic          in_box;
    logic          in_core;

    logic [C:0]    a_next;
    logic [C:0]    b_next;
    logic [C-1:0]  r_next;
    geom_flags_t   flags_next;

    logic [C:0]    a_reg;
    logic [C:0]    b_reg;
    logic [C-1:0]  r_reg;
    geom_flags_t   flags_reg;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_vld)
        begin
            px_reg <= point_x;
            py_reg <= point_y;
        end
    end

    // doubled-unit distance from the mask center
    always_comb
    begin
        dx      = {px_reg[C-1], px_reg} - {offset_x[C-1], offset_x};
        dy      = {py_reg[C-1], py_reg} - {offset_y[C-1], offset_y};
        dx_neg  = ~dx + 1'b1;
        dy_neg  = ~dy + 1'b1;
        mag_x   = dx[C] ? dx_neg[C-1:0] : dx[C-1:0];
        mag_y   = dy[C] ? dy_neg[C-1:0] : dy[C-1:0];
        ax      = {mag_x, 1'b0};
        ay      = {mag_y, 1'b0};
        hw      = {1'b0, size_w};
        hh      = {1'b0, size_h};
        r2      = {corner_radius, 1'b0};
        rc_w    = (r2 < size_w) ? r2 : size_w;
        rc      = (rc_w < size_h) ? rc_w : size_h;
        iw      = size_w - rc;
        ih      = size_h - rc;
        in_box  = (ax <= hw) && (ay <= hh);
        in_core = (ax <= {1'b0, iw}) || (ay <= {1'b0, ih});

        a_next             = ax;
        b_next             = ay;
        r_next             = r2;
        flags_next.valid   = in_vld_reg;
        flags_next.en      = mask_enable;
        flags_next.need_sq = 1'b0;
        flags_next.pre     = 1'b1;
        flags_next.inv     = mask_enable & invert_mask;

        case (shape_kind)
            SHAPE_RECT:
            begin
                flags_next.pre = in_box;
            end
            SHAPE_RRECT:
            begin
                a_next = ax - {1'b0, iw};
                b_next = ay - {1'b0, ih};
                r_next = rc;
                if (!in_box)
                begin
                    flags_next.pre = 1'b0;
                end
                else if (!in_core)
                begin
                    flags_next.need_sq = 1'b1;
                end
            end
            SHAPE_CIRCLE:
            begin
                flags_next.need_sq = 1'b1;
            end
            default:
            begin
                flags_next.pre = 1'b1;
            end
        endcase

        // disabled mask covers everything
        if (!mask_enable)
        begin
            flags_next.need_sq = 1'b0;
            flags_next.pre     = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else
        begin
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        r_reg <= r_next;
    end

    assign a_out = a_reg;
    assign b_out = b_reg;
    assign r_out = r_reg;
    assign flags = flags_reg;

endmodule

`default_nettype wire

FILE: hdl/smpt_dist.sv
`default_nettype none

module smpt_dist
    import smpt_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [COORD_BITS:0]   a_in,
    input  wire logic [COORD_BITS:0]   b_in,
    input  wire logic [COORD_BITS-1:0] r_in,
    input  wire geom_flags_t           flags_in,
    output logic                       done,
    output logic                       inside_res
);

    localparam int C = COORD_BITS;

    logic [2*C+1:0] sq_a_next;
    logic [2*C+1:0] sq_b_next;
    logic [2*C-1:0] sq_r_next;

    logic [2*C+1:0] sq_a_reg;
    logic [2*C+1:0] sq_b_reg;
    logic [2*C-1:0] sq_r_reg;
    geom_flags_t    flags_reg;

    logic [2*C+2:0] sum_sq;
    logic           in_disc;
    logic           inside_next;

    logic           done_reg;
    logic           inside_reg;

    // squares
    always_comb
    begin
        sq_a_next = a_in * a_in;
        sq_b_next = b_in * b_in;
        sq_r_next = r_in * r_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else
        begin
            flags_reg <= flags_in;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_a_reg <= sq_a_next;
        sq_b_reg <= sq_b_next;
        sq_r_reg <= sq_r_next;
    end

    // disc test and final polarity
    always_comb
    begin
        sum_sq      = {1'b0, sq_a_reg} + {1'b0, sq_b_reg};
        in_disc     = sum_sq <= {3'b000, sq_r_reg};
        inside_next = (flags_reg.need_sq ? in_disc : flags_reg.pre) ^ flags_reg.inv;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= flags_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        inside_reg <= inside_next;
    end

    assign done       = done_reg;
    assign inside_res = inside_reg;

endmodule

`default_nettype wire

FILE: hdl/shape_mask_point_test.sv
// channel   signals                               direction  transfer when
// point     start, busy, point_x, point_y         in         start && !busy
// result    done, inside_res                      out        done (one cycle)
// config    cfg_valid, cfg_ready, cfg_index,      in         cfg_valid && cfg_ready
//           cfg_data
//
// one point per clock; busy stays low, so a point is taken on every start
// stages: input register, geometry, squares, disc compare and result register
// reset clears the config registers and the stage valid bits
// the result is not held: it shows for exactly one cycle behind done

`default_nettype none

module shape_mask_point_test
    import smpt_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic signed [COORD_BITS-1:0] point_x,
    input  wire logic signed [COORD_BITS-1:0] point_y,
    output logic                              done,
    output logic                              inside_res,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0]      cfg_index,
    input  wire logic [COORD_BITS-1:0]        cfg_data
);

    logic                         mask_enable;
    shape_t                       shape_kind;
    logic signed [COORD_BITS-1:0] offset_x;
    logic signed [COORD_BITS-1:0] offset_y;
    logic [COORD_BITS-1:0]        size_w;
    logic [COORD_BITS-1:0]        size_h;
    logic [COORD_BITS-2:0]        corner_radius;
    logic                         invert_mask;

    logic [COORD_BITS:0]          geom_a;
    logic [COORD_BITS:0]          geom_b;
    logic [COORD_BITS-1:0]        geom_r;
    geom_flags_t                  geom_flags;

    logic                         in_xfer;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign in_xfer   = start && !busy;

    smpt_cfg #(
        .COORD_BITS (COORD_BITS)
    ) u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .wr_en         (cfg_valid && cfg_ready),
        .wr_index      (cfg_index),
        .wr_data       (cfg_data),
        .mask_enable   (mask_enable),
        .shape_kind    (shape_kind),
        .offset_x      (offset_x),
        .offset_y      (offset_y),
        .size_w        (size_w),
        .size_h        (size_h),
        .corner_radius (corner_radius),
        .invert_mask   (invert_mask)
    );

    smpt_geom #(
        .COORD_BITS (COORD_BITS)
    ) u_geom (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_vld        (in_xfer),
        .point_x       (point_x),
        .point_y       (point_y),
        .mask_enable   (mask_enable),
        .shape_kind    (shape_kind),
        .offset_x      (offset_x),
        .offset_y      (offset_y),
        .size_w        (size_w),
        .size_h        (size_h),
        .corner_radius (corner_radius),
        .invert_mask   (invert_mask),
        .a_out         (geom_a),
        .b_out         (geom_b),
        .r_out         (geom_r),
        .flags         (geom_flags)
    );

    smpt_dist #(
        .COORD_BITS (COORD_BITS)
    ) u_dist (
        .clk        (clk),
        .rst_n      (rst_n),
        .a_in       (geom_a),
        .b_in       (geom_b),
        .r_in       (geom_r),
        .flags_in   (geom_flags),
        .done       (done),
        .inside_res (inside_res)
    );

`ifndef SYNTH
    // every result comes from an earlier point transfer
    ast_done_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 4))
        else $error("result without a matching point transfer");

    // a point taken with the mask disabled reports inside
    ast_disabled_inside: assert property (@(posedge clk) disable iff (!rst_n)
        geom_flags.valid && !geom_flags.en |-> ##2 (done && inside_res))
        else $error("disabled mask did not report inside");

    // a disabled mask never needs the disc test nor inverts
    ast_disabled_flags: assert property (@(posedge clk) disable iff (!rst_n)
        geom_flags.valid && !geom_flags.en |-> !geom_flags.need_sq && !geom_flags.inv)
        else $error("disabled mask routed to disc test or inversion");
`endif

endmodule

`default_nettype wire
